// ===== hw/rtl/jpdt_pkg.sv =====
// ----------------------------------------------------------------------------
// jpdt_pkg
// Shared types, constants and lookup functions of the joint pd torque block.
// ----------------------------------------------------------------------------
`default_nettype none

package jpdt_pkg;

	localparam int NUM_JOINTS_DEF = 16;
	// the joint field is 4 bits wide, so no more than 16 entries can be addressed
	localparam int JOINT_SPAN = 16;

	localparam logic [6:0] FRAME_COUNT_STOP = 7'd100;

	localparam logic [2:0] FLAG_PASSIVE = 3'd2;
	localparam logic [2:0] FLAG_ENABLE  = 3'd5;

	localparam logic signed [15:0] TORQUE_MIN_RST = 16'sh8000;
	localparam logic signed [15:0] TORQUE_MAX_RST = 16'sh7fff;
	localparam logic [15:0] SIGN_MASK_RST = 16'h0000;
	localparam logic [6:0] ENABLE_DELAY_RST = 7'd60;

	localparam logic signed [15:0] TORQUE_NEG_LIMIT = 16'sh8000;
	localparam logic signed [15:0] TORQUE_POS_LIMIT = 16'sh7fff;

	typedef enum logic [1:0] {
		CFG_TORQUE_MIN   = 2'd0,
		CFG_TORQUE_MAX   = 2'd1,
		CFG_SIGN_MASK    = 2'd2,
		CFG_ENABLE_DELAY = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic               control_on;
		logic [3:0]         joint;
		logic signed [15:0] target_pos;
		logic signed [15:0] target_vel;
		logic [15:0]        gain_p;
		logic [15:0]        gain_d;
		logic signed [15:0] torque_ff;
		logic signed [15:0] meas_pos;
		logic signed [15:0] meas_vel;
		logic               frame_end;
	} sample_t;

	typedef struct packed {
		logic [3:0]         joint_out;
		logic [1:0]         board;
		logic [2:0]         slot;
		logic signed [15:0] torque_cmd;
		logic [2:0]         motor_flag;
		logic               clamped;
		logic               frame_last;
	} command_t;

	typedef struct packed {
		logic signed [15:0] torque_min;
		logic signed [15:0] torque_max;
		logic [15:0]        sign_mask;
		logic [6:0]         enable_delay;
	} cfg_t;

	// control law result
	typedef struct packed {
		logic signed [15:0] torque;
		logic               clamped;
	} law_res_t;

	// state update handed to the held torque store
	typedef struct packed {
		logic               we;
		logic [3:0]         joint;
		logic signed [15:0] torque;
		logic               frame_inc;
	} upd_t;

	function automatic logic [1:0] board_of(input logic [3:0] joint);
		logic [1:0] b;
		begin
			if (joint < 4'd6) begin
				b = 2'd0;
			end else if (joint < 4'd11) begin
				b = 2'd1;
			end else begin
				b = 2'd2;
			end
			return b;
		end
	endfunction

	function automatic logic [2:0] slot_of(input logic [3:0] joint);
		logic [2:0] s;
		begin
			case (joint)
				4'd0:  s = 3'd0;
				4'd1:  s = 3'd1;
				4'd2:  s = 3'd2;
				4'd3:  s = 3'd3;
				4'd4:  s = 3'd4;
				4'd5:  s = 3'd5;
				4'd6:  s = 3'd0;
				4'd7:  s = 3'd1;
				4'd8:  s = 3'd3;
				4'd9:  s = 3'd4;
				4'd10: s = 3'd5;
				4'd11: s = 3'd0;
				4'd12: s = 3'd1;
				4'd13: s = 3'd2;
				4'd14: s = 3'd3;
				4'd15: s = 3'd4;
				default: s = 3'd0;
			endcase
			return s;
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jpdt_law.sv =====
// ----------------------------------------------------------------------------
// jpdt_law
// PD control law: two products, floor shift, sum, clamp and signed flip.
// ----------------------------------------------------------------------------
`default_nettype none

module jpdt_law
	import jpdt_pkg::*;
(
	input  var sample_t  samp,
	input  var cfg_t     cfg,
	output law_res_t     res
);

	logic signed [16:0] pos_err;
	logic signed [16:0] vel_err;
	logic signed [16:0] kp;
	logic signed [16:0] kd;
	logic signed [33:0] p_prod;
	logic signed [33:0] d_prod;
	logic signed [25:0] p_term;
	logic signed [25:0] d_term;
	logic signed [27:0] sum;
	logic signed [27:0] lo;
	logic signed [27:0] hi;
	logic signed [15:0] lim;
	logic               clip;

	assign pos_err = 17'(samp.target_pos) - 17'(samp.meas_pos);
	assign vel_err = 17'(samp.target_vel) - 17'(samp.meas_vel);
	assign kp      = $signed({1'b0, samp.gain_p});
	assign kd      = $signed({1'b0, samp.gain_d});

	assign p_prod = 34'(pos_err) * 34'(kp);
	assign d_prod = 34'(vel_err) * 34'(kd);

	// dropping the low byte of a two's complement value rounds toward minus infinity
	assign p_term = p_prod[33:8];
	assign d_term = d_prod[33:8];

	assign sum = 28'(p_term) + 28'(d_term) + 28'(samp.torque_ff);
	assign lo  = 28'(cfg.torque_min);
	assign hi  = 28'(cfg.torque_max);

	// lower limit wins when the limits are inverted
	always_comb begin
		clip = 1'b1;
		if (sum < lo) begin
			lim = cfg.torque_min;
		end else if (sum > hi) begin
			lim = cfg.torque_max;
		end else begin
			lim  = sum[15:0];
			clip = 1'b0;
		end
	end

	always_comb begin
		res.clamped = clip;
		if (cfg.sign_mask[samp.joint]) begin
			res.torque = (lim == TORQUE_NEG_LIMIT) ? TORQUE_POS_LIMIT : -lim;
		end else begin
			res.torque = lim;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/jpdt_state.sv =====
// ----------------------------------------------------------------------------
// jpdt_state
// Per-joint held torque and the saturating frame counter.
// ----------------------------------------------------------------------------
`default_nettype none

module jpdt_state
	import jpdt_pkg::*;
#(
	parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
	input  var logic              clk,
	input  var logic              arst_n,
	input  var logic [3:0]        rd_joint,
	input  var upd_t              upd,
	output logic signed [15:0]    held,
	output logic [6:0]            frame_count
);

	localparam int DEPTH = (NUM_JOINTS < JOINT_SPAN) ? NUM_JOINTS : JOINT_SPAN;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [15:0] held_q [DEPTH];
	logic [6:0]         frame_count_q;
	logic               rd_hit;
	logic               wr_hit;
	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   wr_idx;

	assign rd_hit = 32'(rd_joint) < NUM_JOINTS;
	assign wr_hit = 32'(upd.joint) < NUM_JOINTS;
	assign rd_idx = rd_joint[IDX_W-1:0];
	assign wr_idx = upd.joint[IDX_W-1:0];

	// joints without an entry read as zero
	assign held        = rd_hit ? held_q[rd_idx] : 16'sd0;
	assign frame_count = frame_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				held_q[i] <= 16'sd0;
			end
		end else if (upd.we && wr_hit) begin
			held_q[wr_idx] <= upd.torque;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= 7'd0;
		end else if (upd.frame_inc && (frame_count_q < FRAME_COUNT_STOP)) begin
			frame_count_q <= frame_count_q + 7'd1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/joint_pd_torque_command.sv =====
// ----------------------------------------------------------------------------
// joint_pd_torque_command
// Joint PD torque controller with clamp, per-joint sign and enable sequencing.
// ----------------------------------------------------------------------------
// One joint sample enters per clock and its command leaves by this path:
// the sample is captured in an input register, the PD law, clamp, sign flip and
// flag are worked out in one pass, and the command sits in an output register
// until taken. Throughput is one request per cycle, set by the combinational
// multiply, add and clamp path between those two registers; a stall on the
// command side holds both stages. Control-on samples update the held torque,
// and with frame_end the frame count, as they leave the input register, so the
// next sample sees them. Configuration writes take effect on the next clock.
`default_nettype none

module joint_pd_torque_command
	import jpdt_pkg::*;
#(
	parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        cfg_we,
	input  var logic [1:0]  cfg_index,
	input  var logic [15:0] cfg_data,
	input  var logic        samp_valid,
	output logic            samp_ready,
	input  var sample_t     samp,
	output logic            cmd_valid,
	input  var logic        cmd_ready,
	output command_t        cmd
);

	cfg_t               cfg_q;
	sample_t            samp_s1;
	logic               valid_s1;
	logic               adv_s1;
	command_t           cmd_q;
	logic               cmd_valid_q;
	law_res_t           law;
	upd_t               upd;
	logic signed [15:0] held;
	logic [6:0]         frame_count;
	command_t           cmd_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.torque_min   <= TORQUE_MIN_RST;
			cfg_q.torque_max   <= TORQUE_MAX_RST;
			cfg_q.sign_mask    <= SIGN_MASK_RST;
			cfg_q.enable_delay <= ENABLE_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TORQUE_MIN:   cfg_q.torque_min   <= cfg_data;
				CFG_TORQUE_MAX:   cfg_q.torque_max   <= cfg_data;
				CFG_SIGN_MASK:    cfg_q.sign_mask    <= cfg_data;
				CFG_ENABLE_DELAY: cfg_q.enable_delay <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign adv_s1     = valid_s1 && (!cmd_valid_q || cmd_ready);
	assign samp_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samp_ready) begin
			valid_s1 <= samp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samp_valid && samp_ready) begin
			samp_s1 <= samp;
		end
	end

	jpdt_law u_law (
		.samp (samp_s1),
		.cfg  (cfg_q),
		.res  (law)
	);

	assign upd.we        = adv_s1 && samp_s1.control_on;
	assign upd.joint     = samp_s1.joint;
	assign upd.torque    = law.torque;
	assign upd.frame_inc = adv_s1 && samp_s1.control_on && samp_s1.frame_end;

	jpdt_state #(
		.NUM_JOINTS (NUM_JOINTS)
	) u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_joint    (samp_s1.joint),
		.upd         (upd),
		.held        (held),
		.frame_count (frame_count)
	);

	always_comb begin
		cmd_next.joint_out  = samp_s1.joint;
		cmd_next.board      = board_of(samp_s1.joint);
		cmd_next.slot       = slot_of(samp_s1.joint);
		cmd_next.frame_last = samp_s1.frame_end;
		if (samp_s1.control_on) begin
			cmd_next.torque_cmd = law.torque;
			cmd_next.clamped    = law.clamped;
			cmd_next.motor_flag = (frame_count < cfg_q.enable_delay) ? FLAG_PASSIVE
				: FLAG_ENABLE;
		end else begin
			cmd_next.torque_cmd = held;
			cmd_next.clamped    = 1'b0;
			cmd_next.motor_flag = FLAG_PASSIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (adv_s1) begin
			cmd_valid_q <= 1'b1;
		end else if (cmd_ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			cmd_q <= cmd_next;
		end
	end

	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/jpdt_checker.sv =====
// ----------------------------------------------------------------------------
// jpdt_checker
// Port-level checks on the command side of the joint pd torque block.
// ----------------------------------------------------------------------------
`default_nettype none

module jpdt_checker
	import jpdt_pkg::*;
(
	input var logic     clk,
	input var logic     arst_n,
	input var logic     cmd_valid,
	input var logic     cmd_ready,
	input var command_t cmd
);

	// a stalled command stays up and unchanged
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("command dropped or changed while stalled");

	a_flag_code: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (cmd.motor_flag == FLAG_PASSIVE) || (cmd.motor_flag == FLAG_ENABLE))
		else $error("motor flag is neither passive nor enable");

	a_board_map: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> cmd.board == board_of(cmd.joint_out))
		else $error("board does not match joint");

	a_slot_map: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> cmd.slot == slot_of(cmd.joint_out))
		else $error("slot does not match joint");

endmodule

bind joint_pd_torque_command jpdt_checker u_jpdt_checker (.*);

`default_nettype wire
